// File: sv/assert_macros.svh
// Assertion macros used by the RTL file fastq_record_start_finder.sv.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every rising clock edge out of reset
`define FQ_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Expression must never be true out of reset
`define FQ_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define FQ_ASSERT(lbl, clk, rstn, prop, msg)
`define FQ_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

// File: sv/fqrs_pkg.sv
`default_nettype none

package fqrs_pkg;

	// fixed field widths
	localparam int DATA_BITS = 8;
	localparam int REC_BITS  = 48;
	localparam int CFG_BITS  = 48;

	// line starts kept per segment
	localparam int MAX_LINES = 4;
	localparam int LINE_IDX_BITS = 2;
	localparam int LINE_CNT_BITS = 3;

	// characters of interest
	localparam logic [DATA_BITS-1:0] CH_NL   = 8'h0A;
	localparam logic [DATA_BITS-1:0] CH_AT   = 8'h40;
	localparam logic [DATA_BITS-1:0] CH_PLUS = 8'h2B;

	// configuration register indexes
	localparam logic [0:0] REG_SEG_START = 1'b0;
	localparam logic [0:0] REG_SEG_END   = 1'b1;

	// status codes
	localparam logic STATUS_FOUND    = 1'b0;
	localparam logic STATUS_NO_MARKS = 1'b1;

endpackage

`default_nettype wire

// File: sv/fastq_record_start_finder.sv
// FASTQ record start finder.
// Bytes of one file segment arrive in file order on the s_ channel, one per
// transfer, with s_tlast on the segment's final byte. The block notes the
// first byte and file offset of up to four line starts (a run of newlines is
// one break; the byte at file offset zero is always a line start). On the
// last byte it emits one result on the m_ channel: the offset of the first
// full record in m_tdata and a status flag in m_tuser (1: no valid markers,
// offset zero). All scan state then clears and the offset counter reloads.
// Write seg_start over the cfg channel before a segment; the write also
// loads the offset counter. seg_end is accepted but every decision branch
// picks a line offset or zero, so it is not kept.
// Throughput: one byte per cycle while the result side is not stalled. The
// result is valid in the cycle after the last byte's transfer; byte update
// and decision are one compare and select stage ahead of the result register.
// Reset clears the scan state, seg_start and m_tvalid; the result data is not reset.
// While a result waits with m_tready low, s_tready drops and input stalls;
// input resumes in the same cycle the result is taken.
`default_nettype none
`include "assert_macros.svh"

module fastq_record_start_finder
	import fqrs_pkg::*;
#(
	parameter int OFFSET_BITS = 48
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input byte stream
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [DATA_BITS-1:0] s_tdata,   // [7:0] data_byte
	input  wire logic                 s_tlast,   // last
	// result stream
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [REC_BITS-1:0]       m_tdata,   // [47:0] record_start
	output logic                      m_tuser,   // [0] status
	// configuration writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [0:0]           cfg_index,
	input  wire logic [CFG_BITS-1:0]  cfg_data
);

	localparam int WIDE = (OFFSET_BITS > REC_BITS) ? OFFSET_BITS :
		((OFFSET_BITS > CFG_BITS) ? OFFSET_BITS : REC_BITS);

	logic [OFFSET_BITS-1:0]   seg_start_q;
	logic [OFFSET_BITS-1:0]   pos_q;
	logic                     nl_q;
	logic [LINE_CNT_BITS-1:0] lines_q;
	logic [DATA_BITS-1:0]     first_q [MAX_LINES];
	logic [OFFSET_BITS-1:0]   off_q   [MAX_LINES];

	logic                     in_xfer;
	logic                     cfg_we;
	logic [WIDE-1:0]          cfg_wide;
	logic                     full;
	logic                     at_zero;
	logic                     is_nl;
	logic                     line_start;
	logic                     take;
	logic [DATA_BITS-1:0]     f_n   [MAX_LINES];
	logic [OFFSET_BITS-1:0]   off_n [MAX_LINES];
	logic [OFFSET_BITS-1:0]   sel_pos;
	logic                     sel_status;
	logic [WIDE-1:0]          sel_wide;

	assign s_tready  = !m_tvalid || m_tready;
	assign cfg_ready = 1'b1;
	assign in_xfer   = s_tvalid && s_tready;
	assign cfg_we    = cfg_valid && cfg_ready && (cfg_index == REG_SEG_START);
	assign cfg_wide  = WIDE'(cfg_data);

	// line start detection for the incoming byte
	assign full       = (lines_q >= LINE_CNT_BITS'(MAX_LINES));
	assign at_zero    = (pos_q == '0);
	assign is_nl      = (s_tdata == CH_NL);
	assign line_start = at_zero || (!is_nl && nl_q);
	assign take       = !full && line_start;

	// view of the kept lines including this byte; lines not kept read zero
	always_comb begin
		for (int k = 0; k < MAX_LINES; k++) begin
			if (take && (lines_q == LINE_CNT_BITS'(k))) begin
				f_n[k]   = s_tdata;
				off_n[k] = pos_q;
			end else if (lines_q > LINE_CNT_BITS'(k)) begin
				f_n[k]   = first_q[k];
				off_n[k] = off_q[k];
			end else begin
				f_n[k]   = '0;
				off_n[k] = '0;
			end
		end
	end

	// record start decision from the first bytes of lines 0..2
	always_comb begin
		sel_status = STATUS_FOUND;
		if (f_n[0] == CH_AT) begin
			sel_pos = (f_n[1] != CH_AT) ? off_n[0] : off_n[1];
		end else if (f_n[0] == CH_PLUS) begin
			sel_pos = ((f_n[1] == CH_AT) && (f_n[2] != CH_AT)) ? off_n[1] : off_n[2];
		end else if (f_n[1] == CH_PLUS) begin
			sel_pos = off_n[3];
		end else if (f_n[1] == CH_AT) begin
			sel_pos = off_n[1];
		end else begin
			sel_pos    = '0;
			sel_status = STATUS_NO_MARKS;
		end
	end

	assign sel_wide = WIDE'(sel_pos);

	// configuration register; seg_end has no effect on the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_start_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SEG_START: seg_start_q <= cfg_wide[OFFSET_BITS-1:0];
				REG_SEG_END:   seg_start_q <= seg_start_q;
				default:       seg_start_q <= seg_start_q;
			endcase
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			nl_q    <= 1'b0;
			lines_q <= '0;
		end else if (cfg_we) begin
			pos_q <= cfg_wide[OFFSET_BITS-1:0];
		end else if (in_xfer) begin
			if (s_tlast) begin
				pos_q   <= seg_start_q;
				nl_q    <= 1'b0;
				lines_q <= '0;
			end else begin
				pos_q <= pos_q + OFFSET_BITS'(1);
				if (take) begin
					lines_q <= lines_q + LINE_CNT_BITS'(1);
				end
				if (!full && !at_zero) begin
					if (is_nl) begin
						nl_q <= 1'b1;
					end else if (nl_q) begin
						nl_q <= 1'b0;
					end
				end
			end
		end
	end

	// kept line bytes and offsets, valid below lines_q
	always_ff @(posedge clk) begin
		if (in_xfer && !s_tlast && take) begin
			first_q[lines_q[LINE_IDX_BITS-1:0]] <= s_tdata;
			off_q[lines_q[LINE_IDX_BITS-1:0]]   <= pos_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (in_xfer && s_tlast) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && s_tlast) begin
			m_tdata <= sel_wide[REC_BITS-1:0];
			m_tuser <= sel_status;
		end
	end

	`FQ_NEVER(a_lines_range, clk, arst_n, lines_q > LINE_CNT_BITS'(MAX_LINES), "line count past four")
	`FQ_ASSERT(a_clear_after_last, clk, arst_n, (in_xfer && s_tlast) |=> (lines_q == '0 && !nl_q), "scan state not cleared")
	`FQ_ASSERT(a_stall_blocks, clk, arst_n, (m_tvalid && !m_tready) |-> !s_tready, "input taken over pending result")
	`FQ_ASSERT(a_no_marks_zero, clk, arst_n, (m_tvalid && m_tuser) |-> (m_tdata == '0), "status set with nonzero offset")
	`FQ_ASSERT(a_pos_step, clk, arst_n, (in_xfer && !s_tlast && !cfg_we) |=> (pos_q == $past(pos_q) + OFFSET_BITS'(1)), "offset did not advance")

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb
	import fqrs_pkg::*;
();

	localparam int OFF_W       = 48;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 3000;

	// one byte of a segment, as queued for the driver
	typedef struct packed {
		logic [DATA_BITS-1:0] data;
		logic                 last;
	} seg_byte_t;

	// one record-start answer
	typedef struct packed {
		logic [REC_BITS-1:0] offset;
		logic                status;
	} rec_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [DATA_BITS-1:0] s_tdata = '0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [REC_BITS-1:0]  m_tdata;
	logic                 m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [0:0]           cfg_index = REG_SEG_START;
	logic [CFG_BITS-1:0]  cfg_data = '0;

	fastq_record_start_finder #(
		.OFFSET_BITS(OFF_W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bytes waiting to be offered, and record starts waiting to come out
	seg_byte_t   segment_bytes[$];
	rec_answer_t due_starts[$];

	int unsigned mismatches   = 0;
	int unsigned bytes_queued = 0;
	int unsigned quiet_cycles = 0;
	bit          idle_on      = 1'b0;
	int unsigned hold_ticket  = 0;
	bit          byte_took    = 1'b0;

	// scanner state as seen from outside
	logic [OFF_W-1:0]     seg_base;
	logic [OFF_W-1:0]     seg_limit;
	logic [OFF_W-1:0]     next_offset;
	bit                   after_break;
	logic [2:0]           lines_kept;
	logic [DATA_BITS-1:0] line_chr [MAX_LINES];
	logic [OFF_W-1:0]     line_at  [MAX_LINES];

	function automatic void clear_scan_state();
		next_offset = seg_base;
		after_break = 1'b0;
		lines_kept  = '0;
		for (int k = 0; k < MAX_LINES; k++) begin
			line_chr[k] = '0;
			line_at[k]  = '0;
		end
	endfunction

	function automatic void note_line(logic [DATA_BITS-1:0] c);
		line_chr[lines_kept] = c;
		line_at[lines_kept]  = next_offset;
		lines_kept           = lines_kept + 1'b1;
	endfunction

	// advance the scan by one byte; on the last byte work out the record start
	function automatic void scan_byte(logic [DATA_BITS-1:0] c, logic is_last);
		logic [DATA_BITS-1:0] f0, f1, f2;
		rec_answer_t ans;
		if (lines_kept < MAX_LINES) begin
			if (next_offset == '0)
				note_line(c);
			else if (c == CH_NL)
				after_break = 1'b1;
			else if (after_break) begin
				note_line(c);
				after_break = 1'b0;
			end
		end
		next_offset = next_offset + 1'b1;
		if (is_last) begin
			// lines never captured read as zero
			f0 = (lines_kept > 0) ? line_chr[0] : '0;
			f1 = (lines_kept > 1) ? line_chr[1] : '0;
			f2 = (lines_kept > 2) ? line_chr[2] : '0;
			ans.offset = seg_limit;
			ans.status = STATUS_FOUND;
			if (f0 == CH_AT)
				ans.offset = (f1 != CH_AT) ? line_at[0] : line_at[1];
			else if (f0 == CH_PLUS)
				ans.offset = (f1 == CH_AT && f2 != CH_AT) ? line_at[1] : line_at[2];
			else if (f1 == CH_PLUS)
				ans.offset = line_at[3];
			else if (f1 == CH_AT)
				ans.offset = line_at[1];
			else begin
				ans.offset = '0;
				ans.status = STATUS_NO_MARKS;
			end
			due_starts = {due_starts, ans};
			clear_scan_state();
		end
	endfunction

	// sample all three channels; results are checked before new bytes are scanned
	always @(posedge clk) begin
		rec_answer_t want;
		byte_took = arst_n && s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_starts.size() == 0) begin
				$display("%0t: record start %h status %b with nothing expected",
					$time, m_tdata, m_tuser);
				mismatches++;
			end else begin
				want = due_starts.pop_front();
				if (m_tdata !== want.offset) begin
					$display("%0t: record_start expected %h, got %h",
						$time, want.offset, m_tdata);
					mismatches++;
				end
				if (m_tuser !== want.status) begin
					$display("%0t: status expected %b, got %b",
						$time, want.status, m_tuser);
					mismatches++;
				end
			end
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			if (cfg_index == REG_SEG_START) begin
				seg_base    = cfg_data[OFF_W-1:0];
				next_offset = seg_base;
			end else if (cfg_index == REG_SEG_END)
				seg_limit = cfg_data[OFF_W-1:0];
		end
		if (byte_took)
			scan_byte(s_tdata, s_tlast);
		// watchdog on cycles with no transfer at all
		if (byte_took || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
			$display("fastq_record_start_finder: mismatch");
			$finish;
		end
	end

	// byte driver: holds each byte until it is taken, with idle bursts between
	always @(negedge clk) begin
		seg_byte_t nxt;
		int unsigned tx_gap;
		if (arst_n && !(s_tvalid && !byte_took)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				s_tvalid <= 1'b0;
			end else if (segment_bytes.size() == 0)
				s_tvalid <= 1'b0;
			else if (idle_on && $urandom_range(5) == 0) begin
				tx_gap = $urandom_range(16, 0);
				s_tvalid <= 1'b0;
			end else begin
				nxt = segment_bytes.pop_front();
				s_tdata  <= nxt.data;
				s_tlast  <= nxt.last;
				s_tvalid <= 1'b1;
			end
		end
	end

	// result sink: random stall bursts, plus a long hold when asked for
	always @(negedge clk) begin
		int unsigned rx_gap;
		int unsigned hold_left;
		int unsigned hold_served;
		if (hold_ticket != hold_served) begin
			hold_served = hold_ticket;
			hold_left   = HOLD_CYCLES;
		end
		if (!arst_n)
			m_tready <= 1'b0;
		else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(5) == 0) begin
			rx_gap = $urandom_range(16, 0);
			m_tready <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	function automatic logic [OFF_W-1:0] rand48();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[OFF_W-1:0];
	endfunction

	function automatic logic [DATA_BITS-1:0] body_char();
		logic [DATA_BITS-1:0] bases [5] = '{"A", "C", "G", "T", "N"};
		if ($urandom_range(9) == 0)
			return DATA_BITS'($urandom_range(255));
		return bases[$urandom_range(4)];
	endfunction

	function automatic logic [DATA_BITS-1:0] head_char();
		int unsigned r = $urandom_range(99);
		if (r < 40)
			return CH_AT;
		if (r < 65)
			return CH_PLUS;
		if (r < 92)
			return body_char();
		return DATA_BITS'($urandom_range(255));
	endfunction

	task automatic write_reg(input logic [0:0] idx, input logic [CFG_BITS-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// queue one segment; the final byte carries last
	task automatic queue_segment(input logic [DATA_BITS-1:0] txt[$]);
		seg_byte_t b;
		for (int i = 0; i < txt.size(); i++) begin
			b.data = txt[i];
			b.last = (i == txt.size() - 1);
			segment_bytes = {segment_bytes, b};
		end
		bytes_queued += txt.size();
	endtask

	task automatic queue_text(input string s);
		logic [DATA_BITS-1:0] txt[$];
		for (int i = 0; i < s.len(); i++)
			txt = {txt, DATA_BITS'(s[i])};
		queue_segment(txt);
	endtask

	// FASTQ-like lines with marker heads, sometimes opening mid-line
	task automatic queue_record_segment();
		logic [DATA_BITS-1:0] txt[$];
		int unsigned nlines;
		nlines = $urandom_range(6, 1);
		repeat ($urandom_range(4))
			txt = {txt, body_char()};
		for (int k = 0; k < nlines; k++) begin
			if (k > 0 || txt.size() > 0)
				repeat (($urandom_range(3) == 0) ? $urandom_range(3, 2) : 1)
					txt = {txt, CH_NL};
			txt = {txt, head_char()};
			repeat ($urandom_range(5))
				txt = {txt, body_char()};
		end
		if ($urandom_range(3) == 0)
			txt = {txt, CH_NL};
		queue_segment(txt);
	endtask

	// short segment of arbitrary bytes, rich in markers
	task automatic queue_noise_segment();
		logic [DATA_BITS-1:0] txt[$];
		repeat ($urandom_range(12, 1)) begin
			case ($urandom_range(3))
				0: txt = {txt, CH_NL};
				1: txt = {txt, CH_AT};
				2: txt = {txt, CH_PLUS};
				default: txt = {txt, DATA_BITS'($urandom_range(255))};
			endcase
		end
		queue_segment(txt);
	endtask

	// sender pause: nothing left to offer and every record start delivered
	task automatic wait_idle();
		while (segment_bytes.size() != 0 || s_tvalid || due_starts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [OFF_W-1:0] base;
		int unsigned phase;
		int unsigned phase_bytes;
		seg_base  = '0;
		seg_limit = '0;
		clear_scan_state();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: offset zero, newline runs, wrap, each decision branch
		idle_on = 1'b0;
		write_reg(REG_SEG_START, '0);
		write_reg(REG_SEG_END, '1);
		queue_text("@\nA");
		queue_text("\n\n@");
		wait_idle();
		// offset counter wraps to zero mid-segment
		write_reg(REG_SEG_START, '1 - 1'b1);
		write_reg(REG_SEG_END, '0);
		queue_text("\n@\n+");
		wait_idle();
		write_reg(REG_SEG_START, CFG_BITS'(100));
		queue_text("\n+\n@A");
		queue_text("\n@\n@");
		// more than four line starts, second line a plus
		queue_text("\nA\n+\nB\nC\nD");
		queue_text("Z");
		wait_idle();

		// random phases, each with fresh register values
		phase = 0;
		while (bytes_queued < 630) begin
			idle_on = ($urandom_range(3) != 0);
			case ($urandom_range(4))
				0: base = '0;
				1: base = OFF_W'($urandom_range(1000));
				2: base = '1 - OFF_W'($urandom_range(40));
				default: base = rand48();
			endcase
			if ($urandom_range(1)) begin
				write_reg(REG_SEG_END, rand48());
				write_reg(REG_SEG_START, base);
			end else begin
				write_reg(REG_SEG_START, base);
				write_reg(REG_SEG_END, rand48());
			end
			if (phase == 2) begin
				// long hold on the result side while bytes keep coming
				hold_ticket++;
				repeat (25) queue_noise_segment();
			end else begin
				phase_bytes = bytes_queued;
				while (bytes_queued - phase_bytes < 70) begin
					if ($urandom_range(4) == 0)
						queue_noise_segment();
					else
						queue_record_segment();
				end
			end
			wait_idle();
			phase++;
		end

		// closing stretch at full rate
		idle_on = 1'b0;
		write_reg(REG_SEG_START, OFF_W'($urandom_range(50)));
		phase_bytes = bytes_queued;
		while (bytes_queued - phase_bytes < 60)
			queue_record_segment();
		wait_idle();
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("fastq_record_start_finder: match");
		else
			$display("fastq_record_start_finder: mismatch");
		$finish;
	end

endmodule

// File: sim.f
+incdir+sv
sv/fqrs_pkg.sv
sv/fastq_record_start_finder.sv
verif/tb.sv
